### rtl/core/dnsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsp_pkg
// Shared types and constants of the DNS A record response parser.
// ----------------------------------------------------------------------------
package dnsp_pkg;

    localparam int MAX_MESSAGE = 512;
    localparam int POS_W       = $clog2(MAX_MESSAGE + 1);

    localparam int HDR_LEN  = 12;
    localparam int INFO_LEN = 10;

    localparam logic [15:0] FLAG_MASK  = 16'hFB0F;
    localparam logic [15:0] FLAG_VALUE = 16'h8100;
    localparam logic [7:0]  PTR_MASK   = 8'hC0;

    // header positions that close a field
    localparam int POS_ID      = 1;
    localparam int POS_FLAGS   = 3;
    localparam int POS_QDCOUNT = 5;
    localparam int POS_ANCOUNT = 7;

    // record info byte offsets
    localparam int INFO_TYPE  = 1;
    localparam int INFO_CLASS = 3;

    localparam int ADDR_LEN = 4;

    typedef enum logic [0:0] {
        REG_EXPECTED_ID     = 1'b0,
        REG_QUESTION_LENGTH = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_SKIPQ  = 4'd1,
        PH_NAME   = 4'd2,
        PH_LABEL  = 4'd3,
        PH_PTR    = 4'd4,
        PH_INFO   = 4'd5,
        PH_RDATA  = 4'd6,
        PH_ADDR   = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_FOUND     = 2'd1,
        V_IGNORED   = 2'd2,
        V_FAILED    = 2'd3
    } verdict_t;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FAILED  = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] expected_id;
        logic [8:0]  question_length;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] address;
    } result_t;

endpackage : dnsp_pkg
`default_nettype wire

### rtl/core/dnsp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsp_parse
// Per-byte parse state and verdict logic, one registered byte per cycle while step is high.
// ----------------------------------------------------------------------------
module dnsp_parse (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    input  wire dnsp_pkg::cfg_t   cfg,
    output logic                  res_valid,
    output dnsp_pkg::result_t     res
);

    logic [dnsp_pkg::POS_W-1:0] pos_reg, pos_next;
    dnsp_pkg::phase_t           phase_reg, phase_next;
    logic [15:0]                ans_reg, ans_next;
    logic [15:0]                skip_reg, skip_next;
    logic [15:0]                word_reg, word_next;
    logic                       type_a_reg, type_a_next;
    logic                       class_in_reg, class_in_next;
    logic [31:0]                addr_reg, addr_next;
    dnsp_pkg::verdict_t         verdict_reg, verdict_next;

    logic [15:0] word;
    logic [15:0] ans_dec;
    logic [15:0] skip_dec;
    logic [15:0] skip_inc;

    assign word     = {word_reg[7:0], data_byte};
    assign ans_dec  = ans_reg - 16'd1;
    assign skip_dec = skip_reg - 16'd1;
    assign skip_inc = skip_reg + 16'd1;

    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        ans_next      = ans_reg;
        skip_next     = skip_reg;
        word_next     = word_reg;
        type_a_next   = type_a_reg;
        class_in_next = class_in_reg;
        addr_next     = addr_reg;
        verdict_next  = verdict_reg;
        res_valid     = 1'b0;
        res.status    = dnsp_pkg::ST_FAILED;
        res.address   = 32'd0;

        if (step)
        begin
            if (pos_reg < dnsp_pkg::POS_W'(dnsp_pkg::MAX_MESSAGE))
            begin
                word_next = word;
                pos_next  = pos_reg + dnsp_pkg::POS_W'(1);
                unique case (phase_reg)
                    dnsp_pkg::PH_HEADER:
                    begin
                        priority if (pos_reg == dnsp_pkg::POS_W'(dnsp_pkg::POS_ID)
                                     && word != cfg.expected_id)
                        begin
                            verdict_next = dnsp_pkg::V_IGNORED;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                        else if (pos_reg == dnsp_pkg::POS_W'(dnsp_pkg::POS_FLAGS)
                                 && (word & dnsp_pkg::FLAG_MASK) != dnsp_pkg::FLAG_VALUE)
                        begin
                            verdict_next = dnsp_pkg::V_FAILED;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                        else if (pos_reg == dnsp_pkg::POS_W'(dnsp_pkg::POS_QDCOUNT)
                                 && word != 16'd1)
                        begin
                            verdict_next = dnsp_pkg::V_FAILED;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                        else if (pos_reg == dnsp_pkg::POS_W'(dnsp_pkg::POS_ANCOUNT))
                        begin
                            ans_next = word;
                            if (word == 16'd0)
                            begin
                                verdict_next = dnsp_pkg::V_FAILED;
                                phase_next   = dnsp_pkg::PH_DONE;
                            end
                        end
                        else if (pos_reg == dnsp_pkg::POS_W'(dnsp_pkg::HDR_LEN - 1))
                        begin
                            skip_next  = {7'd0, cfg.question_length};
                            phase_next = (cfg.question_length == 9'd0) ?
                                         dnsp_pkg::PH_NAME : dnsp_pkg::PH_SKIPQ;
                        end
                        else
                        begin
                            phase_next = dnsp_pkg::PH_HEADER;
                        end
                    end
                    dnsp_pkg::PH_SKIPQ, dnsp_pkg::PH_LABEL:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 16'd0)
                        begin
                            phase_next = dnsp_pkg::PH_NAME;
                        end
                    end
                    dnsp_pkg::PH_NAME:
                    begin
                        priority if (data_byte == 8'd0)
                        begin
                            skip_next  = 16'd0;
                            phase_next = dnsp_pkg::PH_INFO;
                        end
                        else if ((data_byte & dnsp_pkg::PTR_MASK) == dnsp_pkg::PTR_MASK)
                        begin
                            phase_next = dnsp_pkg::PH_PTR;
                        end
                        else if ((data_byte & dnsp_pkg::PTR_MASK) == 8'd0)
                        begin
                            skip_next  = {8'd0, data_byte};
                            phase_next = dnsp_pkg::PH_LABEL;
                        end
                        else
                        begin
                            // reserved label prefix
                            verdict_next = dnsp_pkg::V_FAILED;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                    end
                    dnsp_pkg::PH_PTR:
                    begin
                        skip_next  = 16'd0;
                        phase_next = dnsp_pkg::PH_INFO;
                    end
                    dnsp_pkg::PH_INFO:
                    begin
                        if (skip_reg == 16'(dnsp_pkg::INFO_TYPE))
                        begin
                            type_a_next = (word == 16'd1);
                        end
                        else if (skip_reg == 16'(dnsp_pkg::INFO_CLASS))
                        begin
                            class_in_next = (word == 16'd1);
                        end
                        skip_next = skip_inc;
                        if (skip_inc == 16'(dnsp_pkg::INFO_LEN))
                        begin
                            // word holds rdlength here
                            priority if (type_a_reg && class_in_reg
                                         && word == 16'(dnsp_pkg::ADDR_LEN))
                            begin
                                skip_next  = 16'd0;
                                addr_next  = 32'd0;
                                phase_next = dnsp_pkg::PH_ADDR;
                            end
                            else if (word == 16'd0)
                            begin
                                ans_next = ans_dec;
                                if (ans_dec == 16'd0)
                                begin
                                    verdict_next = dnsp_pkg::V_FAILED;
                                    phase_next   = dnsp_pkg::PH_DONE;
                                end
                                else
                                begin
                                    phase_next = dnsp_pkg::PH_NAME;
                                end
                            end
                            else
                            begin
                                skip_next  = word;
                                phase_next = dnsp_pkg::PH_RDATA;
                            end
                        end
                    end
                    dnsp_pkg::PH_RDATA:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 16'd0)
                        begin
                            ans_next = ans_dec;
                            if (ans_dec == 16'd0)
                            begin
                                verdict_next = dnsp_pkg::V_FAILED;
                                phase_next   = dnsp_pkg::PH_DONE;
                            end
                            else
                            begin
                                phase_next = dnsp_pkg::PH_NAME;
                            end
                        end
                    end
                    dnsp_pkg::PH_ADDR:
                    begin
                        addr_next = {addr_reg[23:0], data_byte};
                        skip_next = skip_inc;
                        if (skip_inc == 16'(dnsp_pkg::ADDR_LEN))
                        begin
                            verdict_next = dnsp_pkg::V_FOUND;
                            phase_next   = dnsp_pkg::PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            if (last_byte)
            begin
                res_valid = 1'b1;
                priority if (pos_next < dnsp_pkg::POS_W'(dnsp_pkg::HDR_LEN)
                             || verdict_next == dnsp_pkg::V_IGNORED)
                begin
                    res.status = dnsp_pkg::ST_IGNORED;
                end
                else if (verdict_next == dnsp_pkg::V_FOUND)
                begin
                    res.status  = dnsp_pkg::ST_FOUND;
                    res.address = addr_next;
                end
                else
                begin
                    res.status = dnsp_pkg::ST_FAILED;
                end
                // fresh state for the next datagram
                pos_next      = '0;
                phase_next    = dnsp_pkg::PH_HEADER;
                ans_next      = 16'd0;
                skip_next     = 16'd0;
                word_next     = 16'd0;
                type_a_next   = 1'b0;
                class_in_next = 1'b0;
                addr_next     = 32'd0;
                verdict_next  = dnsp_pkg::V_UNDECIDED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= dnsp_pkg::PH_HEADER;
            ans_reg      <= 16'd0;
            skip_reg     <= 16'd0;
            word_reg     <= 16'd0;
            type_a_reg   <= 1'b0;
            class_in_reg <= 1'b0;
            addr_reg     <= 32'd0;
            verdict_reg  <= dnsp_pkg::V_UNDECIDED;
        end
        else
        begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            ans_reg      <= ans_next;
            skip_reg     <= skip_next;
            word_reg     <= word_next;
            type_a_reg   <= type_a_next;
            class_in_reg <= class_in_next;
            addr_reg     <= addr_next;
            verdict_reg  <= verdict_next;
        end
    end

endmodule : dnsp_parse
`default_nettype wire

### rtl/core/dnsp_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsp_out
// Result register holding one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module dnsp_out (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire dnsp_pkg::result_t res,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output dnsp_pkg::result_t      m_res,
    output logic                   busy
);

    logic              valid_reg, valid_next;
    dnsp_pkg::result_t res_reg, res_next;

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;
    // a waiting verdict blocks only the next final byte
    assign busy     = valid_reg && !m_tready;

endmodule : dnsp_out
`default_nettype wire

### rtl/core/dns_a_record_response_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_a_record_response_parser
// Checks a DNS response datagram and extracts the first A/IN address.
// ----------------------------------------------------------------------------
// Takes one datagram byte per cycle and gives one verdict per datagram on the
// byte flagged by s_tlast: status 0 with the address, 1 for an ignored
// datagram (short or wrong ID), 2 for a failed lookup. Throughput is one byte
// every cycle, set by the parse state update behind the input register; the
// verdict of the final byte is registered in the result register and appears
// on m_tvalid from there. The input stalls only while a final byte waits for a
// verdict that has not yet been taken. Configure expected_id and question_length
// while no datagram is in flight.
module dns_a_record_response_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // last_byte
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] address
    output logic [1:0]       m_tuser,   // [1:0] status
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [15:0] expected_id_reg;
    logic [8:0]  question_length_reg;

    logic              advance;
    logic              step;
    logic              out_busy;
    logic              res_valid;
    dnsp_pkg::result_t res;
    dnsp_pkg::result_t m_res;
    dnsp_pkg::cfg_t    cfg;

    assign advance  = !(in_last_reg && out_busy);
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_id_reg     <= 16'd0;
            question_length_reg <= 9'd5;
        end
        else if (cfg_we)
        begin
            unique case (dnsp_pkg::reg_index_t'(cfg_index))
                dnsp_pkg::REG_EXPECTED_ID:     expected_id_reg     <= cfg_data;
                dnsp_pkg::REG_QUESTION_LENGTH: question_length_reg <= cfg_data[8:0];
                default:                       expected_id_reg     <= expected_id_reg;
            endcase
        end
    end

    assign cfg.expected_id     = expected_id_reg;
    assign cfg.question_length = question_length_reg;

    dnsp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    dnsp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (res_valid),
        .res      (res),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_res    (m_res),
        .busy     (out_busy)
    );

    assign m_tdata = m_res.address;
    assign m_tuser = m_res.status;

endmodule : dns_a_record_response_parser
`default_nettype wire

### rtl/core/dnsp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnsp_checker
// Port-level checks of the DNS A record response parser.
// ----------------------------------------------------------------------------
module dnsp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [1:0]  m_tuser
);

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("verdict changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == dnsp_pkg::ST_FOUND || m_tuser == dnsp_pkg::ST_IGNORED
                      || m_tuser == dnsp_pkg::ST_FAILED))
        else $error("undefined status code");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != dnsp_pkg::ST_FOUND |-> m_tdata == 32'd0)
        else $error("address set without a found verdict");

    // input only stalls behind a waiting verdict
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no verdict waiting");

endmodule : dnsp_checker

bind dns_a_record_response_parser dnsp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### dv/dns_a_record_response_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_a_record_response_parser_tb
// Self-checking bench for the DNS A record response parser.
// ----------------------------------------------------------------------------
// Streams response datagrams into the parser one byte per item. A local model
// follows the header checks, the question skip and the answer walk, and
// predicts the verdict for every datagram. Each verdict on the result stream
// is compared with the oldest prediction. Both stream sides idle in random
// bursts, and the configuration is changed between datagrams.
// ----------------------------------------------------------------------------
module dns_a_record_response_parser_tb;
    import dnsp_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          ITEM_TARGET    = 1100;
    localparam int          SHOW_LIMIT     = 10;
    localparam logic [15:0] TYPE_A         = 16'd1;
    localparam logic [15:0] TYPE_CNAME     = 16'd5;
    localparam logic [15:0] TYPE_AAAA      = 16'd28;
    localparam logic [15:0] CLASS_IN       = 16'd1;
    localparam logic [15:0] CLASS_CH       = 16'd3;
    localparam logic [15:0] LOOKUP_FLAGS   = 16'h8180;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    // local copy of the configuration and of the parse state
    logic [15:0]      cur_id;
    logic [8:0]       cur_qlen;
    logic [POS_W-1:0] seen_cnt;
    phase_t           phase;
    logic [15:0]      answers_open;
    logic [15:0]      run_cnt;
    logic [15:0]      word16;
    logic [15:0]      rec_type;
    logic [15:0]      rec_class;
    logic [31:0]      addr_acc;
    verdict_t         outcome;

    result_t     verdicts_due[$];
    result_t     want_res;
    logic [7:0]  dgram[$];

    int mismatches  = 0;
    int sent_bytes  = 0;
    int n_found     = 0;
    int n_ignored   = 0;
    int n_failed    = 0;
    int n_settings  = 0;
    int n_random    = 0;
    int quiet_cycles = 0;
    int rx_hold     = 0;
    bit tx_idle_on;
    bit rx_idle_on;

    always #1 clk = ~clk;

    dns_a_record_response_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // datagram model
    // ------------------------------------------------------------------------
    function automatic void restart_parse();
        seen_cnt     = '0;
        phase        = PH_HEADER;
        answers_open = '0;
        run_cnt      = '0;
        word16       = '0;
        rec_type     = '0;
        rec_class    = '0;
        addr_acc     = '0;
        outcome      = V_UNDECIDED;
    endfunction

    function automatic void conclude(input verdict_t v);
        outcome = v;
        phase   = PH_DONE;
    endfunction

    function automatic void close_record();
        answers_open = answers_open - 16'd1;
        if (answers_open == 16'd0)
            conclude(V_FAILED);
        else
            phase = PH_NAME;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b, input logic lst);
        logic [15:0] rdlen;
        result_t     res;
        // bytes past the message limit only carry their last mark
        if (seen_cnt < MAX_MESSAGE)
        begin
            word16 = {word16[7:0], b};
            case (phase)
                PH_HEADER:
                begin
                    if (seen_cnt == POS_ID && word16 != cur_id)
                        conclude(V_IGNORED);
                    else if (seen_cnt == POS_FLAGS && (word16 & FLAG_MASK) != FLAG_VALUE)
                        conclude(V_FAILED);
                    else if (seen_cnt == POS_QDCOUNT && word16 != 16'd1)
                        conclude(V_FAILED);
                    else if (seen_cnt == POS_ANCOUNT)
                    begin
                        answers_open = word16;
                        if (answers_open == 16'd0)
                            conclude(V_FAILED);
                    end
                    else if (seen_cnt == HDR_LEN - 1)
                    begin
                        run_cnt = {7'd0, cur_qlen};
                        phase   = (run_cnt == 16'd0) ? PH_NAME : PH_SKIPQ;
                    end
                end
                PH_SKIPQ, PH_LABEL:
                begin
                    run_cnt = run_cnt - 16'd1;
                    if (run_cnt == 16'd0)
                        phase = PH_NAME;
                end
                PH_NAME:
                begin
                    if (b == 8'h00)
                    begin
                        run_cnt = '0;
                        phase   = PH_INFO;
                    end
                    else if ((b & PTR_MASK) == PTR_MASK)
                        phase = PH_PTR;
                    else if ((b & PTR_MASK) == 8'h00)
                    begin
                        run_cnt = {8'h00, b};
                        phase   = PH_LABEL;
                    end
                    else
                        conclude(V_FAILED);
                end
                PH_PTR:
                begin
                    run_cnt = '0;
                    phase   = PH_INFO;
                end
                PH_INFO:
                begin
                    if (run_cnt == INFO_TYPE)
                        rec_type = word16;
                    else if (run_cnt == INFO_CLASS)
                        rec_class = word16;
                    run_cnt = run_cnt + 16'd1;
                    if (run_cnt == INFO_LEN)
                    begin
                        rdlen = word16;
                        if (rec_type == TYPE_A && rec_class == CLASS_IN && rdlen == ADDR_LEN)
                        begin
                            run_cnt  = '0;
                            addr_acc = '0;
                            phase    = PH_ADDR;
                        end
                        else if (rdlen == 16'd0)
                            close_record();
                        else
                        begin
                            run_cnt = rdlen;
                            phase   = PH_RDATA;
                        end
                    end
                end
                PH_RDATA:
                begin
                    run_cnt = run_cnt - 16'd1;
                    if (run_cnt == 16'd0)
                        close_record();
                end
                PH_ADDR:
                begin
                    addr_acc = {addr_acc[23:0], b};
                    run_cnt  = run_cnt + 16'd1;
                    if (run_cnt == ADDR_LEN)
                        conclude(V_FOUND);
                end
                default: ;
            endcase
            seen_cnt = seen_cnt + 1'b1;
        end
        if (lst)
        begin
            res.address = '0;
            if (seen_cnt < HDR_LEN || outcome == V_IGNORED)
            begin
                res.status = ST_IGNORED;
                n_ignored++;
            end
            else if (outcome == V_FOUND)
            begin
                res.status  = ST_FOUND;
                res.address = addr_acc;
                n_found++;
            end
            else
            begin
                res.status = ST_FAILED;
                n_failed++;
            end
            verdicts_due.push_back(res);
            restart_parse();
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking and input tracking
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("unexpected verdict: status %0d address %h", m_tuser, m_tdata);
                end
                else
                begin
                    want_res = verdicts_due.pop_front();
                    if (m_tuser !== want_res.status || m_tdata !== want_res.address)
                    begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display("verdict mismatch: expected status %0d address %h, got status %0d address %h",
                                     want_res.status, want_res.address, m_tuser, m_tdata);
                    end
                end
            end
            // check first so a verdict pushed now is never taken in the same cycle
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tlast);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side back-pressure in random bursts
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (rx_idle_on && $urandom_range(0, 7) == 0)
        begin
            rx_hold = $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_bytes++;
    endtask

    task automatic send_datagram();
        for (int i = 0; i < dgram.size(); i++)
            send_byte(dgram[i], i == dgram.size() - 1);
        dgram.delete();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] id, input logic [15:0] qlen_word);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_EXPECTED_ID;
        cfg_data  <= id;
        @(posedge clk);
        cfg_index <= REG_QUESTION_LENGTH;
        cfg_data  <= qlen_word;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_id   = id;
        cur_qlen = qlen_word[8:0];
        n_settings++;
    endtask

    function automatic void put16(input logic [15:0] v);
        dgram.push_back(v[15:8]);
        dgram.push_back(v[7:0]);
    endfunction

    function automatic void put_fill(input int n, input int pattern = -1);
        repeat (n)
            dgram.push_back(pattern < 0 ? 8'($urandom) : 8'(pattern));
    endfunction

    function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                       input logic [15:0] qd, input logic [15:0] an);
        put16(id);
        put16(flags);
        put16(qd);
        put16(an);
        put16(16'($urandom));
        put16(16'($urandom));
    endfunction

    function automatic void put_response(input logic [15:0] an);
        put_header(cur_id, LOOKUP_FLAGS, 16'd1, an);
        put_fill(cur_qlen);
    endfunction

    // style 0 pointer, 1 root, 2 labels then zero, 3 labels then pointer
    function automatic void put_name(input int style);
        int labels;
        int len;
        if (style == 1)
            dgram.push_back(8'h00);
        else
        begin
            if (style != 0)
            begin
                labels = $urandom_range(1, 3);
                repeat (labels)
                begin
                    len = $urandom_range(1, 6);
                    dgram.push_back(8'(len));
                    put_fill(len);
                end
            end
            if (style == 2)
                dgram.push_back(8'h00);
            else
            begin
                dgram.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
                dgram.push_back(8'($urandom));
            end
        end
    endfunction

    function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                       input logic [15:0] rdlen, input int style,
                                       input int pattern = -1);
        put_name(style);
        put16(rtype);
        put16(rclass);
        put_fill(4);
        put16(rdlen);
        put_fill(rdlen, pattern);
    endfunction

    function automatic void keep(input int n);
        while (dgram.size() > n)
            void'(dgram.pop_back());
    endfunction

    function automatic void make_random_dgram();
        int          kind;
        int          an;
        logic [15:0] rt;
        logic [15:0] rc;
        logic [15:0] rl;
        kind = $urandom_range(0, 9);
        if (kind == 9)
        begin
            // plain noise, sometimes with a matching id
            put_fill($urandom_range(1, 40));
            if (dgram.size() >= 2 && $urandom_range(0, 1) == 1)
            begin
                dgram[0] = cur_id[15:8];
                dgram[1] = cur_id[7:0];
            end
            return;
        end
        an = $urandom_range(1, 3);
        put_header(cur_id, FLAG_VALUE | (16'($urandom) & ~FLAG_MASK), 16'd1, 16'(an));
        put_fill(cur_qlen);
        for (int r = 0; r < an; r++)
        begin
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    rt = TYPE_A;
                    rc = CLASS_IN;
                    rl = 16'(ADDR_LEN);
                end
                2:
                begin
                    rt = TYPE_A;
                    rc = ($urandom_range(0, 1) == 1) ? CLASS_IN : 16'($urandom);
                    rl = 16'($urandom_range(0, 6));
                end
                default:
                begin
                    rt = 16'($urandom);
                    rc = CLASS_IN;
                    rl = 16'($urandom_range(0, 8));
                end
            endcase
            put_record(rt, rc, rl, $urandom_range(0, 3));
        end
        if ($urandom_range(0, 3) == 0)
            put_fill($urandom_range(1, 8));
        if (kind == 7)
            keep($urandom_range(1, dgram.size() - 1));
        else if (kind == 8)
            repeat ($urandom_range(1, 2))
                dgram[$urandom_range(0, dgram.size() - 1)] = 8'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_header_checks();
        put_response(1);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0, 255);
        send_datagram();
        put_header(cur_id, FLAG_VALUE | ~FLAG_MASK, 16'd1, 16'd1);
        put_fill(cur_qlen);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0, 0);
        send_datagram();
        // single byte, then one byte short of a header, then a bare header
        dgram.push_back(8'hFF);
        send_datagram();
        put_response(1);
        keep(HDR_LEN - 1);
        send_datagram();
        put_response(1);
        keep(HDR_LEN);
        send_datagram();
        // wrong id wins over bad flags
        put_header(~cur_id, 16'h0000, 16'd1, 16'd1);
        put_fill(cur_qlen);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
        put_header(cur_id, 16'h0100, 16'd1, 16'd1);
        put_fill(cur_qlen);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
        put_header(cur_id, LOOKUP_FLAGS, 16'd2, 16'd1);
        put_fill(cur_qlen);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
        put_response(0);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
        put_response(16'hFFFF);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 2);
        send_datagram();
    endtask

    task automatic test_name_walk();
        // longest label, then a short one, then the root
        put_response(1);
        dgram.push_back(8'h3F);
        put_fill(63);
        dgram.push_back(8'h01);
        put_fill(1);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 1);
        send_datagram();
        put_response(1);
        dgram.push_back(8'h40);
        put_fill(16);
        send_datagram();
        put_response(1);
        dgram.push_back(8'h80);
        put_fill(16);
        send_datagram();
        put_response(2);
        put_record(TYPE_CNAME, CLASS_IN, 16'd6, 2);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 3);
        send_datagram();
        put_response(2);
        put_record(TYPE_AAAA, CLASS_IN, 16'd0, 0);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
        // no usable address before the answers run out
        put_response(1);
        put_record(TYPE_A, CLASS_IN, 16'd5, 0);
        send_datagram();
        put_response(2);
        put_record(TYPE_A, CLASS_CH, 16'(ADDR_LEN), 1);
        put_record(TYPE_AAAA, CLASS_IN, 16'd16, 0);
        send_datagram();
    endtask

    task automatic test_truncation();
        int cuts[5];
        cuts = '{2, 6, 7, 12, 16};
        // question, record info and address cut short
        foreach (cuts[i])
        begin
            put_response(1);
            put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
            keep(HDR_LEN + cuts[i] + (i == 0 ? 0 : cur_qlen - 2));
            send_datagram();
        end
        put_response(1);
        put_name(2);
        keep(HDR_LEN + cur_qlen + 2);
        send_datagram();
        put_response(1);
        put_record(TYPE_CNAME, CLASS_IN, 16'd6, 0);
        keep(HDR_LEN + cur_qlen + 15);
        send_datagram();
    endtask

    task automatic test_config_extremes();
        set_config(16'hFFFF, 16'd0);
        // answers right after the header, with bytes after the verdict
        put_response(1);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        put_fill(6);
        send_datagram();
        put_header(16'h0000, LOOKUP_FLAGS, 16'd1, 16'd1);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
        set_config(16'($urandom), 16'd288);
        put_response(1);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 3);
        send_datagram();
        // upper bits beyond the question length field are dropped
        set_config(16'h0000, 16'hFE05);
        put_response(1);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 2);
        send_datagram();
    endtask

    task automatic test_oversized();
        // the address record sits past the message limit and is never seen
        put_response(2);
        put_record(TYPE_CNAME, CLASS_IN, 16'd490, 0);
        put_record(TYPE_A, CLASS_IN, 16'(ADDR_LEN), 0);
        send_datagram();
    endtask

    task automatic test_random_traffic();
        logic [15:0] qlen_word;
        while (sent_bytes < ITEM_TARGET || n_random < 30)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                case ($urandom_range(0, 7))
                    0:       qlen_word = 16'd0;
                    1:       qlen_word = 16'd288;
                    default: qlen_word = 16'($urandom_range(1, 12));
                endcase
                set_config(16'($urandom), qlen_word);
            end
            else if ($urandom_range(0, 11) == 0)
                wait_idle();
            if ($urandom_range(0, 5) == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            make_random_dgram();
            send_datagram();
            n_random++;
        end
    endtask

    task automatic test_no_idle_tail();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (6)
        begin
            make_random_dgram();
            send_datagram();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_EXPECTED_ID;
        cfg_data   = '0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        cur_id     = 16'd0;
        cur_qlen   = 9'd5;
        restart_parse();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_checks();
        test_name_walk();
        test_truncation();
        test_config_extremes();
        test_oversized();
        test_random_traffic();
        test_no_idle_tail();

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes in %0d datagrams: %0d found, %0d ignored, %0d failed",
                 sent_bytes, n_found + n_ignored + n_failed, n_found, n_ignored, n_failed);
        $display("%0d configuration settings, %0d random datagrams, %0d mismatches",
                 n_settings, n_random, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
